/* rtl/core/hvn_pkg.sv */
// Shared types and constants for the heightmap vertex normal unit.
// No dependencies; imported by every module of the block but the port checker.
package hvn_pkg;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int DIM_W    = 11;
  localparam int STEP_W   = 19;
  localparam int SCALE_W  = 16;
  localparam int GRAD_W   = 11;
  localparam int NRM_W    = 16;

  localparam logic [NRM_W-1:0] UNIT_ONE = 16'd16384;

  // One queued job: an interior vertex to normalize or a fixed (0,0,1) normal.
  typedef struct packed {
    logic                     interior;
    logic signed [GRAD_W-1:0] grad_a;
    logic signed [GRAD_W-1:0] grad_b;
    logic [ROW_W-1:0]         vrow;
    logic [COL_W-1:0]         vcol;
    logic                     last;
  } job_t;

  // Up to two jobs per accepted beat; slot a is always used first.
  typedef struct packed {
    logic a_vld;
    logic b_vld;
    job_t a;
    job_t b;
  } push_t;

endpackage

/* rtl/core/hvn_front.sv */
// Front end: raster counters, two-line buffer memory and 3x3 window.
// Classifies each vertex and pushes jobs; depends on hvn_pkg.
module hvn_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [hvn_pkg::DIM_W-1:0] rows_cfg,
  input  logic [hvn_pkg::DIM_W-1:0] cols_cfg,
  input  logic                  restart,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_height,
  input  logic                  space_ok,
  output hvn_pkg::push_t        push
);
  import hvn_pkg::*;

  // Each entry holds {older line, previous line} for one column.
  logic [15:0] line_mem [MAX_COLS];
  logic [15:0] rd0_r, rd1_r;
  logic        rd_ok_r, rd_ok_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [7:0]  w1_r, w2_r;
  logic [DIM_W-1:0] rows_eff, cols_eff, col_p1, row_p1;
  logic        accept, interior;
  logic signed [11:0] hn_s, hne_s, hw_s, he_s, hsw_s, hs_s, a_sum, b_sum;
  job_t        vjob, bjob;

  always_comb begin
    if (rows_cfg < DIM_W'(3)) rows_eff = DIM_W'(3);
    else if (rows_cfg > DIM_W'(MAX_ROWS)) rows_eff = DIM_W'(MAX_ROWS);
    else rows_eff = rows_cfg;
    if (cols_cfg < DIM_W'(3)) cols_eff = DIM_W'(3);
    else if (cols_cfg > DIM_W'(MAX_COLS)) cols_eff = DIM_W'(MAX_COLS);
    else cols_eff = cols_cfg;
  end

  assign col_p1   = DIM_W'(col_r) + DIM_W'(1);
  assign row_p1   = DIM_W'(row_r) + DIM_W'(1);
  assign in_ready = rd_ok_r && space_ok;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    rd0_r <= line_mem[col_r];
    rd1_r <= line_mem[col_r + COL_W'(1)];
    if (accept) begin
      line_mem[col_r] <= {rd0_r[7:0], in_height};
    end
  end

  assign hn_s  = $signed({4'd0, rd0_r[15:8]});
  assign hne_s = $signed({4'd0, rd1_r[15:8]});
  assign hw_s  = $signed({4'd0, w1_r});
  assign he_s  = $signed({4'd0, rd1_r[7:0]});
  assign hsw_s = $signed({4'd0, w2_r});
  assign hs_s  = $signed({4'd0, in_height});
  assign a_sum = (hn_s <<< 1) + hne_s + hw_s - he_s - hsw_s - (hs_s <<< 1);
  assign b_sum = (hw_s <<< 1) + hn_s + hsw_s - hne_s - (he_s <<< 1) - hs_s;
  assign interior = (row_r >= ROW_W'(2)) && (col_r != '0) && (col_p1 < cols_eff);

  always_comb begin
    vjob.interior = interior;
    vjob.grad_a   = a_sum[GRAD_W-1:0];
    vjob.grad_b   = b_sum[GRAD_W-1:0];
    vjob.vrow     = row_r - ROW_W'(1);
    vjob.vcol     = col_r;
    vjob.last     = 1'b0;
    bjob.interior = 1'b0;
    bjob.grad_a   = '0;
    bjob.grad_b   = '0;
    bjob.vrow     = row_r;
    bjob.vcol     = col_r;
    bjob.last     = (col_p1 == cols_eff);
    push.a_vld = 1'b0;
    push.b_vld = 1'b0;
    push.a     = vjob;
    push.b     = bjob;
    if (accept) begin
      if (row_r != '0) begin
        push.a_vld = 1'b1;
        push.b_vld = (row_p1 == rows_eff);
      end else begin
        push.a     = bjob;
        push.a_vld = (row_p1 == rows_eff);
      end
    end
  end

  always_comb begin
    row_nxt   = row_r;
    col_nxt   = col_r;
    rd_ok_nxt = 1'b1;
    if (restart) begin
      row_nxt   = '0;
      col_nxt   = '0;
      rd_ok_nxt = 1'b0;
    end else if (accept) begin
      rd_ok_nxt = 1'b0;
      if (col_p1 >= cols_eff) begin
        col_nxt = '0;
        row_nxt = (row_p1 >= rows_eff) ? '0 : row_p1[ROW_W-1:0];
      end else begin
        col_nxt = col_p1[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r   <= '0;
      col_r   <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      rd_ok_r <= rd_ok_nxt;
    end
  end

  // The window taps clear on reset and load on every accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w1_r <= '0;
      w2_r <= '0;
    end else if (accept) begin
      w1_r <= rd0_r[7:0];
      w2_r <= in_height;
    end
  end

endmodule

/* rtl/core/hvn_queue.sv */
// Four-entry job queue between front and back end; takes up to two jobs a beat.
// Depends on hvn_pkg.
module hvn_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  hvn_pkg::push_t push,
  input  logic           pop,
  output hvn_pkg::job_t  head,
  output logic           empty,
  output logic           space_ok
);
  import hvn_pkg::*;

  job_t       store [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign head     = store[rp_r];
  assign empty    = (cnt_r == 3'd0);
  assign space_ok = (cnt_r <= 3'd2);

  always_ff @(posedge clk) begin
    if (push.a_vld) store[wp_r] <= push.a;
    if (push.b_vld) store[wp_r + 2'd1] <= push.b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + 2'(push.a_vld) + 2'(push.b_vld);
      rp_r  <= rp_r + 2'(pop);
      cnt_r <= cnt_r + 3'(push.a_vld) + 3'(push.b_vld) - 3'(pop);
    end
  end

endmodule

/* rtl/core/hvn_back.sv */
// Back end: scales the gradient sums, normalizes with an iterative square root
// and three long divisions, and holds the result beat. Depends on hvn_pkg.
module hvn_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [hvn_pkg::STEP_W-1:0]  grid_step,
  input  logic [hvn_pkg::SCALE_W-1:0] height_scale,
  input  hvn_pkg::job_t               head,
  input  logic                        empty,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [15:0]          out_normal_x,
  output logic signed [15:0]          out_normal_y,
  output logic signed [15:0]          out_normal_z,
  output logic [9:0]                  out_vertex_row,
  output logic [9:0]                  out_vertex_col,
  output logic                        out_last_of_frame
);
  import hvn_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MULA = 9'b000000010,
    S_MULB = 9'b000000100,
    S_NORM = 9'b000001000,
    S_SQ   = 9'b000010000,
    S_SQRT = 9'b000100000,
    S_DSET = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_OUT  = 9'b100000000
  } bstate_t;

  bstate_t     st_r;
  job_t        job_r;
  logic [25:0] ax_r, ay_r, az_r, sel, mag;
  logic [51:0] prod_r;
  logic [53:0] acc_r, sqv_r;
  logic [29:0] rem_r, remn, trial;
  logic [26:0] root_r;
  logic [41:0] drem_r;
  logic [40:0] dv_r;
  logic [14:0] q_r, qn;
  logic [4:0]  step_r;
  logic [1:0]  comp_r;
  logic [15:0] res_x_r, res_y_r, res_z_r, sres;
  logic [10:0] a_abs, b_abs;
  logic        ge, neg;

  assign pop   = (st_r == S_IDLE) && !empty;
  assign a_abs = job_r.grad_a[GRAD_W-1] ? 11'(-job_r.grad_a) : 11'(job_r.grad_a);
  assign b_abs = job_r.grad_b[GRAD_W-1] ? 11'(-job_r.grad_b) : 11'(job_r.grad_b);

  always_comb begin
    case (step_r[1:0])
      2'd0:    sel = ax_r;
      2'd1:    sel = ay_r;
      default: sel = az_r;
    endcase
    case (comp_r)
      2'd0:    begin mag = ax_r; neg = job_r.grad_a[GRAD_W-1]; end
      2'd1:    begin mag = ay_r; neg = job_r.grad_b[GRAD_W-1]; end
      default: begin mag = az_r; neg = 1'b0; end
    endcase
  end

  assign remn  = {rem_r[27:0], sqv_r[53:52]};
  assign trial = {1'b0, root_r, 2'b01};
  assign ge    = ({1'b0, drem_r} >= {2'b0, dv_r});
  assign qn    = {q_r[13:0], ge};
  assign sres  = neg ? (16'd0 - {1'b0, qn}) : {1'b0, qn};

  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        job_r   <= head;
        res_x_r <= '0;
        res_y_r <= '0;
        res_z_r <= UNIT_ONE;
      end
      S_MULA: begin
        ax_r <= 26'(a_abs[9:0]) * 26'(height_scale);
        az_r <= 26'({grid_step, 6'd0}) + 26'({grid_step, 5'd0});
      end
      S_MULB: ay_r <= 26'(b_abs[9:0]) * 26'(height_scale);
      S_NORM: begin
        if (!(ax_r[25] || ay_r[25] || az_r[25])) begin
          ax_r <= ax_r << 1;
          ay_r <= ay_r << 1;
          az_r <= az_r << 1;
        end
        step_r <= '0;
        acc_r  <= '0;
      end
      S_SQ: begin
        prod_r <= 52'(sel) * 52'(sel);
        if (step_r != '0) acc_r <= acc_r + 54'(prod_r);
        sqv_r  <= acc_r + 54'(prod_r);
        rem_r  <= '0;
        root_r <= '0;
        step_r <= (step_r == 5'd3) ? 5'd0 : step_r + 5'd1;
        comp_r <= '0;
      end
      S_SQRT: begin
        sqv_r <= sqv_r << 2;
        if (remn >= trial) begin
          rem_r  <= remn - trial;
          root_r <= {root_r[25:0], 1'b1};
        end else begin
          rem_r  <= remn;
          root_r <= {root_r[25:0], 1'b0};
        end
        step_r <= step_r + 5'd1;
      end
      S_DSET: begin
        drem_r <= {2'b0, mag, 14'd0} + 42'(root_r[26:1]);
        dv_r   <= {root_r, 14'd0};
        q_r    <= '0;
        step_r <= 5'd14;
      end
      S_DIV: begin
        if (ge) drem_r <= drem_r - 42'(dv_r);
        dv_r   <= dv_r >> 1;
        q_r    <= qn;
        step_r <= step_r - 5'd1;
        if (step_r == '0) begin
          case (comp_r)
            2'd0:    res_x_r <= sres;
            2'd1:    res_y_r <= sres;
            default: res_z_r <= sres;
          endcase
          comp_r <= comp_r + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      unique case (st_r)
        S_IDLE: if (!empty) st_r <= head.interior ? S_MULA : S_OUT;
        S_MULA: st_r <= S_MULB;
        S_MULB: st_r <= S_NORM;
        S_NORM: begin
          if ((ax_r | ay_r | az_r) == '0) st_r <= S_OUT;
          else if (ax_r[25] || ay_r[25] || az_r[25]) st_r <= S_SQ;
        end
        S_SQ:   if (step_r == 5'd3) st_r <= S_SQRT;
        S_SQRT: if (step_r == 5'd26) st_r <= S_DSET;
        S_DSET: st_r <= S_DIV;
        S_DIV:  if (step_r == '0) st_r <= (comp_r == 2'd2) ? S_OUT : S_DSET;
        S_OUT:  if (!out_valid || out_ready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (st_r == S_OUT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_OUT && (!out_valid || out_ready)) begin
      out_normal_x      <= res_x_r;
      out_normal_y      <= res_y_r;
      out_normal_z      <= res_z_r;
      out_vertex_row    <= job_r.vrow;
      out_vertex_col    <= job_r.vcol;
      out_last_of_frame <= job_r.last;
    end
  end

endmodule

/* rtl/core/heightmap_vertex_normals_unit.sv */
// Heightmap vertex normals: the front end reads the line buffers and, after each accepted
// height beat, waits for a fresh line-buffer read before it takes the next. The back end
// takes one job at a time: an interior normal gets a normalizing shift, a 27-step square
// root and three 15-step divisions; a zero summed vector skips the root and divisions,
// and a border normal goes straight to the output. Synchronous active-low reset clears
// counters, window, queue and handshakes; line memory is not cleared.
module heightmap_vertex_normals_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_height,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_normal_x,
  output logic signed [15:0] out_normal_y,
  output logic signed [15:0] out_normal_z,
  output logic [9:0]         out_vertex_row,
  output logic [9:0]         out_vertex_col,
  output logic               out_last_of_frame,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [18:0]        cfg_data
);
  import hvn_pkg::*;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_ROWS  = 2'd0;
  localparam logic [1:0] REG_COLS  = 2'd1;
  localparam logic [1:0] REG_STEP  = 2'd2;
  localparam logic [1:0] REG_SCALE = 2'd3;

  logic [DIM_W-1:0]   rows_r, cols_r;
  logic [STEP_W-1:0]  step_r;
  logic [SCALE_W-1:0] scale_r;
  logic               cfg_acc, restart, space_ok, empty, pop;
  push_t              push;
  job_t               head;

  // Configuration is always taken; a geometry write restarts the frame.
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign restart   = cfg_acc && (cfg_index == REG_ROWS || cfg_index == REG_COLS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= DIM_W'(512);
      cols_r  <= DIM_W'(512);
      step_r  <= STEP_W'(800);
      scale_r <= SCALE_W'(5140);
    end else if (cfg_acc) begin
      unique case (cfg_index)
        REG_ROWS:  rows_r  <= cfg_data[DIM_W-1:0];
        REG_COLS:  cols_r  <= cfg_data[DIM_W-1:0];
        REG_STEP:  step_r  <= cfg_data;
        REG_SCALE: scale_r <= cfg_data[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  hvn_front u_front (
    .clk(clk), .rst_n(rst_n), .rows_cfg(rows_r), .cols_cfg(cols_r),
    .restart(restart), .in_valid(in_valid), .in_ready(in_ready),
    .in_height(in_height), .space_ok(space_ok), .push(push)
  );

  hvn_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .pop(pop), .head(head),
    .empty(empty), .space_ok(space_ok)
  );

  hvn_back u_back (
    .clk(clk), .rst_n(rst_n), .grid_step(step_r), .height_scale(scale_r),
    .head(head), .empty(empty), .pop(pop), .out_valid(out_valid),
    .out_ready(out_ready), .out_normal_x(out_normal_x),
    .out_normal_y(out_normal_y), .out_normal_z(out_normal_z),
    .out_vertex_row(out_vertex_row), .out_vertex_col(out_vertex_col),
    .out_last_of_frame(out_last_of_frame)
  );

endmodule

/* rtl/core/hvn_checker.sv */
// Port-level checks for the heightmap vertex normal unit, bound to the top.
// Depends only on the top-level ports.
module hvn_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_normal_x,
  input logic signed [15:0] out_normal_y,
  input logic signed [15:0] out_normal_z,
  input logic               out_last_of_frame
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_normal_x)
      && $stable(out_normal_y) && $stable(out_normal_z))
    else $error("result beat changed while stalled");

  a_z_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_normal_z[15] && out_normal_z <= 16'sd16384)
    else $error("normal z out of range");

  a_last_border: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_frame |-> out_normal_x == 16'sd0
      && out_normal_y == 16'sd0 && out_normal_z == 16'sd16384)
    else $error("frame-end normal is not a border normal");

endmodule

bind heightmap_vertex_normals_unit hvn_checker u_hvn_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
  .out_normal_x(out_normal_x), .out_normal_y(out_normal_y),
  .out_normal_z(out_normal_z), .out_last_of_frame(out_last_of_frame)
);

/* bench/hvn_tb_pkg.sv */
// Register indexes shared by the vertex normal bench files.
// No dependencies; imported by the checker and by tb_top.
package hvn_tb_pkg;

  typedef enum logic [1:0] {
    REG_ROWS  = 2'd0,
    REG_COLS  = 2'd1,
    REG_STEP  = 2'd2,
    REG_SCALE = 2'd3
  } hvn_reg_e;

endpackage

/* bench/hvn_normal_checker.sv */
// Watches the height, normal and register channels of the vertex normal unit,
// predicts every normal and compares it. Depends on hvn_pkg and hvn_tb_pkg.
module hvn_normal_checker
  import hvn_pkg::*;
  import hvn_tb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         in_height,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] out_normal_x,
  input  logic signed [15:0] out_normal_y,
  input  logic signed [15:0] out_normal_z,
  input  logic [9:0]         out_vertex_row,
  input  logic [9:0]         out_vertex_col,
  input  logic               out_last_of_frame,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [18:0]        cfg_data,
  output int                 mismatches,
  output int                 pending
);

  typedef struct {
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic [9:0]  row;
    logic [9:0]  col;
    logic        last;
  } normal_t;

  normal_t     normals_due[$];
  logic [7:0]  far_line [MAX_COLS];
  logic [7:0]  near_line[MAX_COLS];
  logic [7:0]  win[6];
  int          cur_row, cur_col;
  logic [10:0] rows_reg, cols_reg;
  logic [18:0] step_reg;
  logic [15:0] scale_reg;

  function automatic int clamp_dim(input int v, input int maxv);
    if (v < 3) return 3;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Rounds half away from zero: magnitude is rounded, then the sign applied.
  function automatic logic [15:0] unit_comp(input longint unsigned mag, input bit neg,
                                            input longint unsigned len);
    longint unsigned q = (mag * 16384 + len / 2) / len;
    logic [15:0] q16 = q[15:0];
    return neg ? -q16 : q16;
  endfunction

  function automatic normal_t flat_normal(input int r, input int c, input bit last);
    normal_t n;
    n.nx = '0; n.ny = '0; n.nz = UNIT_ONE;
    n.row = r[9:0]; n.col = c[9:0]; n.last = last;
    return n;
  endfunction

  function automatic normal_t unit_normal(input longint x, input longint y, input longint z,
                                          input int r, input int c);
    normal_t n;
    longint unsigned ax = x < 0 ? -x : x;
    longint unsigned ay = y < 0 ? -y : y;
    longint unsigned az = z < 0 ? -z : z;
    longint unsigned m, len;
    m = ax;
    if (ay > m) m = ay;
    if (az > m) m = az;
    if (m == 0) return flat_normal(r, c, 1'b0);
    while (m < (64'd1 << 25)) begin
      ax <<= 1; ay <<= 1; az <<= 1; m <<= 1;
    end
    len = int_sqrt(ax * ax + ay * ay + az * az);
    n = flat_normal(r, c, 1'b0);
    n.nx = unit_comp(ax, x < 0, len);
    n.ny = unit_comp(ay, y < 0, len);
    n.nz = unit_comp(az, z < 0, len);
    return n;
  endfunction

  task automatic predict_height(input logic [7:0] h);
    int rows, cols, r, c;
    longint hn, hne, hw, he, hsw, hs, a, b;
    rows = clamp_dim(rows_reg, MAX_ROWS);
    cols = clamp_dim(cols_reg, MAX_COLS);
    r = cur_row;
    c = cur_col;
    if (c >= cols) c = cols - 1;
    win[3] = far_line[c];
    win[4] = near_line[c];
    win[5] = h;
    if (r >= 1) begin
      if (r >= 2 && c >= 1 && c + 1 < cols) begin
        hn = win[3]; hne = far_line[c+1]; hw = win[1];
        he = near_line[c+1]; hsw = win[2]; hs = h;
        a = 2 * hn + hne + hw - he - hsw - 2 * hs;
        b = 2 * hw + hn + hsw - hne - 2 * he - hs;
        normals_due.push_back(unit_normal(a * longint'(scale_reg), b * longint'(scale_reg),
                                          96 * longint'(step_reg), r - 1, c));
      end else begin
        normals_due.push_back(flat_normal(r - 1, c, 1'b0));
      end
    end
    if (r + 1 == rows) normals_due.push_back(flat_normal(r, c, c + 1 == cols));
    far_line[c] = win[4];
    near_line[c] = h;
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    c++;
    if (c >= cols) begin
      c = 0;
      r++;
      if (r >= rows) r = 0;
    end
    cur_row = r;
    cur_col = c;
  endtask

  task automatic check_normal();
    normal_t e;
    if (normals_due.size() == 0) begin
      $display("%0t: normal (%0d,%0d) arrived with none expected", $time,
               out_vertex_row, out_vertex_col);
      mismatches++;
      return;
    end
    e = normals_due.pop_front();
    if (out_normal_x !== e.nx || out_normal_y !== e.ny || out_normal_z !== e.nz ||
        out_vertex_row !== e.row || out_vertex_col !== e.col ||
        out_last_of_frame !== e.last) begin
      $display("%0t: expected n=(%0d,%0d,%0d) v=(%0d,%0d) last=%0b", $time,
               $signed(e.nx), $signed(e.ny), $signed(e.nz), e.row, e.col, e.last);
      $display("%0t: actual   n=(%0d,%0d,%0d) v=(%0d,%0d) last=%0b", $time,
               out_normal_x, out_normal_y, out_normal_z, out_vertex_row,
               out_vertex_col, out_last_of_frame);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      normals_due.delete();
      foreach (far_line[i]) begin
        far_line[i] = '0;
        near_line[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      cur_row = 0;
      cur_col = 0;
      rows_reg = 11'd512;
      cols_reg = 11'd512;
      step_reg = 19'd800;
      scale_reg = 16'd5140;
      mismatches = 0;
    end else begin
      if (out_valid && out_ready) check_normal();
      if (cfg_valid && cfg_ready) begin
        case (hvn_reg_e'(cfg_index))
          REG_ROWS: begin
            rows_reg = cfg_data[10:0];
            cur_row = 0; cur_col = 0;
          end
          REG_COLS: begin
            cols_reg = cfg_data[10:0];
            cur_row = 0; cur_col = 0;
          end
          REG_STEP:  step_reg = cfg_data;
          REG_SCALE: scale_reg = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_height(in_height);
    end
    pending = normals_due.size();
  end

endmodule

/* bench/tb_top.sv */
// Top of the vertex normal bench: clock, reset, height and register stimulus,
// result back-pressure and the verdict. Depends on hvn_tb_pkg, the checker and the RTL.
module tb_top;
  import hvn_tb_pkg::*;

  // Receiver back-pressure styles; a new one is drawn when the current one runs out.
  localparam int RX_OPEN   = 0;
  localparam int RX_RANDOM = 1;
  localparam int RX_STALLS = 2;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         in_height;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] out_normal_x, out_normal_y, out_normal_z;
  logic [9:0]         out_vertex_row, out_vertex_col;
  logic               out_last_of_frame;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [18:0]        cfg_data;
  int                 mismatches;
  int                 pending;

  // Shadow of the geometry, used only to size frames in the stimulus.
  int rows_set = 512;
  int cols_set = 512;
  int burst_left = 0;

  always #10 clk = ~clk;

  heightmap_vertex_normals_unit dut (.*);

  hvn_normal_checker checker_i (.*);

  // The receiver switches between always ready, coin-flip ready and long stalls.
  int rx_mode = RX_OPEN;
  int rx_left = 0;
  int hold_left = 0;

  initial out_ready = 1'b0;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(RX_OPEN, RX_STALLS);
      rx_left <= $urandom_range(100, 400);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
      default: begin
        if (hold_left > 0) begin
          out_ready <= 1'b0;
          hold_left <= hold_left - 1;
        end else begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 9) == 0) hold_left <= $urandom_range(5, 40);
        end
      end
    endcase
  end

  // All tasks are entered and left at a falling edge.
  task automatic write_reg(input hvn_reg_e idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[18:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_ROWS) rows_set = value;
    if (idx == REG_COLS) cols_set = value;
  endtask

  // Sends one height beat and then, at the end of a burst, maybe a gap.
  task automatic send_height(input logic [7:0] h);
    int gap;
    in_valid  <= 1'b1;
    in_height <= h;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  function automatic logic [7:0] pick_height();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random(input int n);
    repeat (n) send_height(pick_height());
  endtask

  // Holds off the sender until every normal is back, then keeps it idle
  // a while longer before it returns.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  function automatic int eff_dim(input int v);
    if (v < 3) return 3;
    if (v > 1024) return 1024;
    return v;
  endfunction

  function automatic int pick_dim();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 9);
  endfunction

  initial begin
    int rand_items;
    int n;
    logic [7:0] checker_heights[9] = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0,
                                       8'd255, 8'd255, 8'd0};
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_height = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_ROWS;
    cfg_data  = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Smallest frame with the largest step and scale: rows and columns below
    // the minimum are clamped up to three.
    write_reg(REG_ROWS, 0);
    write_reg(REG_COLS, 2);
    write_reg(REG_STEP, 524287);
    write_reg(REG_SCALE, 65535);
    foreach (checker_heights[i]) send_height(checker_heights[i]);
    wait_idle();

    // Zero step and zero scale make the summed vector zero, which must still
    // give the upward unit normal.
    write_reg(REG_ROWS, 3);
    write_reg(REG_COLS, 3);
    write_reg(REG_STEP, 0);
    write_reg(REG_SCALE, 0);
    repeat (9) send_height(8'd0);
    wait_idle();

    // Tall frame, only partly sent; the next geometry write restarts it.
    write_reg(REG_STEP, 800);
    write_reg(REG_SCALE, 5140);
    write_reg(REG_ROWS, 2047);
    write_reg(REG_COLS, 3);
    send_random(15);
    wait_idle();

    // Random phases: mostly whole frames, sometimes a tail of a next frame
    // that is then cut off by a geometry write.
    rand_items = 0;
    while (rand_items < 800) begin
      if ($urandom_range(0, 3) != 0) write_reg(REG_ROWS, pick_dim());
      if ($urandom_range(0, 3) != 0) write_reg(REG_COLS, pick_dim());
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 3))
          0:       write_reg(REG_STEP, 1);
          1:       write_reg(REG_STEP, 524287);
          2:       write_reg(REG_STEP, $urandom_range(1, 2000));
          default: write_reg(REG_STEP, $urandom_range(0, 524287));
        endcase
      end
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 3))
          0:       write_reg(REG_SCALE, 0);
          1:       write_reg(REG_SCALE, 65535);
          default: write_reg(REG_SCALE, $urandom_range(0, 65535));
        endcase
      end
      n = $urandom_range(1, 2) * eff_dim(rows_set) * eff_dim(cols_set);
      if ($urandom_range(0, 3) == 0) n += $urandom_range(1, 2 * eff_dim(cols_set));
      send_random(n);
      rand_items += n;
      wait_idle();
    end

    repeat (300) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of the stimulus above.
  initial begin
    #60000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
